FILE: src/c8i_pkg.sv
// Shared types and constants for the CHIP-8 instruction core.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package c8i_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int ADDR_W      = 12;
  localparam int SCREEN_COLS = 64;
  localparam int SCREEN_ROWS = 32;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 6;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = 4;
  localparam int NUM_REGS    = 16;

  localparam logic [ADDR_W-1:0] PROGRAM_START = 12'd512;
  localparam logic [3:0]        FLAG_IDX      = 4'hF;
  localparam logic [7:0]        KK_CLS        = 8'hE0;
  localparam logic [7:0]        KK_RET        = 8'hEE;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_STEP  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Instruction families (top nibble).
  typedef enum logic [3:0] {
    OP_SYS      = 4'h0,
    OP_JUMP     = 4'h1,
    OP_CALL     = 4'h2,
    OP_SKIP_EQ  = 4'h3,
    OP_SKIP_NE  = 4'h4,
    OP_SKIP_REG = 4'h5,
    OP_LOAD     = 4'h6,
    OP_ADD_IMM  = 4'h7,
    OP_ALU      = 4'h8,
    OP_LOAD_I   = 4'hA,
    OP_DRAW     = 4'hD
  } op_e;

  // Register-register operations (low nibble of family 8).
  typedef enum logic [3:0] {
    ALU_MOV = 4'h0,
    ALU_OR  = 4'h1,
    ALU_AND = 4'h2,
    ALU_XOR = 4'h3,
    ALU_ADD = 4'h4,
    ALU_SUB = 4'h5
  } alu_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic fetch_hi;
    logic fetch_lo;
    logic read_x;
    logic read_y;
    logic exec;
    logic draw_rd;
    logic draw_wr;
    logic finish;
  } c8i_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic step_req;
    logic draw_go;
    logic draw_last;
    logic out_free;
  } c8i_status_t;

endpackage

`default_nettype wire

FILE: src/c8i_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module c8i_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/c8i_ctrl.sv
// Controller state machine for the CHIP-8 instruction core.
// Depends on c8i_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module c8i_ctrl import c8i_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire c8i_status_t status_i,
  output c8i_cmd_t         cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_FETCH_HI = 10'b00_0000_0100,
    S_FETCH_LO = 10'b00_0000_1000,
    S_READ_X   = 10'b00_0001_0000,
    S_READ_Y   = 10'b00_0010_0000,
    S_EXEC     = 10'b00_0100_0000,
    S_DRAW_RD  = 10'b00_1000_0000,
    S_DRAW_WR  = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Decode the state into datapath commands.
  always_comb begin
    cmd_o            = '0;
    cmd_o.clear_step = (state_q == S_CLEAR);
    cmd_o.accept     = accept;
    cmd_o.fetch_hi   = (state_q == S_FETCH_HI);
    cmd_o.fetch_lo   = (state_q == S_FETCH_LO);
    cmd_o.read_x     = (state_q == S_READ_X);
    cmd_o.read_y     = (state_q == S_READ_Y);
    cmd_o.exec       = (state_q == S_EXEC);
    cmd_o.draw_rd    = (state_q == S_DRAW_RD);
    cmd_o.draw_wr    = (state_q == S_DRAW_WR);
    cmd_o.finish     = (state_q == S_FINISH) && status_i.out_free;
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = status_i.step_req ? S_FETCH_HI : S_FINISH;
      end
      S_FETCH_HI: state_d = S_FETCH_LO;
      S_FETCH_LO: state_d = S_READ_X;
      S_READ_X:   state_d = S_READ_Y;
      S_READ_Y:   state_d = S_EXEC;
      S_EXEC: begin
        state_d = status_i.draw_go ? S_DRAW_RD : S_FINISH;
      end
      S_DRAW_RD:  state_d = S_DRAW_WR;
      S_DRAW_WR: begin
        state_d = status_i.draw_last ? S_FINISH : S_DRAW_RD;
      end
      S_FINISH: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default:    state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/c8i_dpath.sv
// Datapath of the CHIP-8 instruction core: memory, registers, display, stack.
// Depends on c8i_pkg and instantiates c8i_ram for program memory.
`timescale 1ns / 1ps
`default_nettype none

module c8i_dpath import c8i_pkg::*; #(
  parameter logic [ADDR_W-1:0] ProgramStart = PROGRAM_START
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire c8i_cmd_t          cmd_i,
  output c8i_status_t            status_o,
  input  wire logic [1:0]        func_i,
  input  wire logic [ADDR_W-1:0] mem_address_i,
  input  wire logic [7:0]        mem_data_i,
  input  wire logic [ROW_W-1:0]  row_select_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ADDR_W-1:0]      prog_count_o,
  output logic [15:0]            instr_word_o,
  output logic [7:0]             flag_reg_o,
  output logic [SCREEN_COLS-1:0] row_bits_o
);

  // Architectural state.
  logic [ADDR_W-1:0]      pc_q, pc_d;
  logic [ADDR_W-1:0]      idx_q, idx_d;
  logic [SP_W-1:0]        sp_q, sp_d;
  logic [7:0]             regs_q [NUM_REGS];
  logic [ADDR_W-1:0]      stack_q [STACK_DEPTH];
  logic [SCREEN_COLS-1:0] disp_q [SCREEN_ROWS];

  // Request and instruction working registers.
  func_e             func_q;
  logic [ROW_W-1:0]  row_sel_q;
  logic [7:0]        hi_q, lo_q, a_q, b_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [COL_W-1:0]  x0_q;
  logic [ROW_W-1:0]  y0_q;
  logic [3:0]        r_q;
  logic              hit_q;

  // Memory port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // Instruction fields.
  logic [15:0]       op;
  logic [3:0]        op_x, op_y, op_n;
  logic [7:0]        op_kk;
  logic [ADDR_W-1:0] op_nnn;

  // Execution results.
  logic              vx_we, vf_we, disp_clr, stack_we;
  logic [7:0]        vx_wd, vf_wd;
  logic [8:0]        sum9;
  logic [ADDR_W-1:0] pc_skip;

  // Draw signals.
  logic [ROW_W-1:0]       draw_row;
  logic [ROW_W-1:0]       disp_raddr;
  logic [SCREEN_COLS-1:0] disp_row;
  logic [SCREEN_COLS-1:0] sprite_mask;
  logic [3:0]             r_next;
  logic [ROW_W:0]         y_next;
  logic                   hit_now;

  assign op     = {hi_q, lo_q};
  assign op_x   = hi_q[3:0];
  assign op_y   = lo_q[7:4];
  assign op_n   = lo_q[3:0];
  assign op_kk  = lo_q;
  assign op_nnn = op[ADDR_W-1:0];

  // Program memory write port is shared by the clearing pass and write requests.
  assign ram_we    = cmd_i.clear_step || (cmd_i.accept && (func_e'(func_i) == FUNC_WRITE));
  assign ram_waddr = cmd_i.clear_step ? clr_cnt_q : mem_address_i;
  assign ram_wdata = cmd_i.clear_step ? 8'd0 : mem_data_i;

  // Read address: instruction bytes or sprite rows.
  always_comb begin
    ram_raddr = pc_q;
    if (cmd_i.fetch_hi) ram_raddr = pc_q;
    if (cmd_i.fetch_lo) ram_raddr = pc_q + ADDR_W'(1);
    if (cmd_i.draw_rd)  ram_raddr = idx_q + ADDR_W'(r_q);
  end

  c8i_ram #(
    .Width (8),
    .Depth (MEM_BYTES)
  ) u_prog_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Display row read and the shifted sprite row for the current draw step.
  assign draw_row    = y0_q + ROW_W'(r_q);
  assign disp_raddr  = cmd_i.draw_wr ? draw_row : row_sel_q;
  assign disp_row    = disp_q[disp_raddr];
  assign sprite_mask = {ram_rdata, {(SCREEN_COLS-8){1'b0}}} >> x0_q;
  assign hit_now     = |(disp_row & sprite_mask);
  assign r_next      = r_q + 4'd1;
  assign y_next      = {1'b0, y0_q} + {{(ROW_W-3){1'b0}}, r_next};

  // Status back to the controller.
  assign status_o.clear_last = (clr_cnt_q == {ADDR_W{1'b1}});
  assign status_o.step_req   = (func_e'(func_i) == FUNC_STEP);
  assign status_o.draw_go    = (op_e'(hi_q[7:4]) == OP_DRAW) && (op_n != 4'd0);
  assign status_o.draw_last  = (r_next == op_n) || (y_next >= (ROW_W+1)'(SCREEN_ROWS));
  assign status_o.out_free   = !out_valid_o || out_ready_i;

  assign sum9    = {1'b0, a_q} + {1'b0, b_q};
  assign pc_skip = pc_q + ADDR_W'(2);

  // Instruction execution.
  always_comb begin
    pc_d     = pc_q;
    idx_d    = idx_q;
    sp_d     = sp_q;
    vx_we    = 1'b0;
    vx_wd    = 8'd0;
    vf_we    = 1'b0;
    vf_wd    = 8'd0;
    disp_clr = 1'b0;
    stack_we = 1'b0;
    if (cmd_i.fetch_lo) begin
      pc_d = pc_skip;
    end
    if (cmd_i.exec) begin
      case (op_e'(hi_q[7:4]))
        OP_SYS: begin
          if (op_kk == KK_CLS) begin
            disp_clr = 1'b1;
          end else if (op_kk == KK_RET) begin
            pc_d = stack_q[sp_q];
            sp_d = sp_q - SP_W'(1);
          end
        end
        OP_JUMP: pc_d = op_nnn;
        OP_CALL: begin
          sp_d     = sp_q + SP_W'(1);
          stack_we = 1'b1;
          pc_d     = op_nnn;
        end
        OP_SKIP_EQ:  if (a_q == op_kk) pc_d = pc_skip;
        OP_SKIP_NE:  if (a_q != op_kk) pc_d = pc_skip;
        OP_SKIP_REG: if ((op_n == 4'd0) && (a_q == b_q)) pc_d = pc_skip;
        OP_LOAD: begin
          vx_we = 1'b1;
          vx_wd = op_kk;
        end
        OP_ADD_IMM: begin
          vx_we = 1'b1;
          vx_wd = a_q + op_kk;
        end
        OP_ALU: begin
          case (alu_e'(op_n))
            ALU_MOV: begin vx_we = 1'b1; vx_wd = b_q;       end
            ALU_OR:  begin vx_we = 1'b1; vx_wd = a_q | b_q; end
            ALU_AND: begin vx_we = 1'b1; vx_wd = a_q & b_q; end
            ALU_XOR: begin vx_we = 1'b1; vx_wd = a_q ^ b_q; end
            ALU_ADD: begin
              vx_we = 1'b1;
              vx_wd = sum9[7:0];
              vf_we = 1'b1;
              vf_wd = {7'd0, sum9[8]};
            end
            ALU_SUB: begin
              vx_we = 1'b1;
              vx_wd = a_q - b_q;
              vf_we = 1'b1;
              vf_wd = {7'd0, (a_q >= b_q)};
            end
            default: ;
          endcase
        end
        OP_LOAD_I: idx_d = op_nnn;
        OP_DRAW: begin
          // An empty sprite touches nothing but still clears the flag.
          if (op_n == 4'd0) begin
            vf_we = 1'b1;
            vf_wd = 8'd0;
          end
        end
        default: ;
      endcase
    end
    // Last sprite row: publish the collision flag.
    if (cmd_i.draw_wr && status_o.draw_last) begin
      vf_we = 1'b1;
      vf_wd = {7'd0, (hit_q || hit_now)};
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ProgramStart;
      idx_q       <= '0;
      sp_q        <= '0;
      clr_cnt_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      idx_q <= idx_d;
      sp_q  <= sp_d;
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      if (cmd_i.finish) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Data registers; when both write the same register, the flag write wins over the destination write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= 8'd0;
    end else begin
      if (vx_we) regs_q[op_x] <= vx_wd;
      if (vf_we) regs_q[FLAG_IDX] <= vf_wd;
    end
  end

  // Display rows: whole-screen clear or one sprite row per draw step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SCREEN_ROWS; i++) disp_q[i] <= '0;
    end else if (disp_clr) begin
      for (int i = 0; i < SCREEN_ROWS; i++) disp_q[i] <= '0;
    end else if (cmd_i.draw_wr) begin
      disp_q[draw_row] <= disp_row ^ sprite_mask;
    end
  end

  // Return stack entries hold the address after the call.
  always_ff @(posedge clk_i) begin
    if (stack_we) stack_q[sp_d] <= pc_q;
  end

  // Request capture, instruction bytes, operands, draw progress, result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q    <= func_e'(func_i);
      row_sel_q <= row_select_i;
    end
    if (cmd_i.fetch_lo) hi_q <= ram_rdata;
    if (cmd_i.read_x) begin
      lo_q <= ram_rdata;
      a_q  <= regs_q[op_x];
    end
    if (cmd_i.read_y) b_q <= regs_q[op_y];
    if (cmd_i.exec) begin
      x0_q  <= a_q[COL_W-1:0];
      y0_q  <= b_q[ROW_W-1:0];
      r_q   <= 4'd0;
      hit_q <= 1'b0;
    end
    if (cmd_i.draw_wr) begin
      r_q   <= r_next;
      hit_q <= hit_q || hit_now;
    end
    if (cmd_i.finish) begin
      prog_count_o <= pc_q;
      instr_word_o <= (func_q == FUNC_STEP) ? op : 16'd0;
      flag_reg_o   <= regs_q[FLAG_IDX];
      row_bits_o   <= (func_q == FUNC_READ) ? disp_row : '0;
    end
  end

endmodule

`default_nettype wire

FILE: src/chip8_instruction_core.sv
// Top level of the CHIP-8 instruction core: controller plus datapath.
// Depends on c8i_pkg, c8i_ctrl, c8i_dpath and c8i_ram.
`timescale 1ns / 1ps
`default_nettype none

// CHIP-8 instruction core. After reset the block sweeps its 4096-byte program
// memory to zero, one byte a cycle, and accepts no request until the sweep is
// done. It then handles one request at a time: a memory write or a display
// row read goes from acceptance straight to the result state, an instruction
// step passes two reads of the single memory port for the fetch, two register
// reads, execute and result, and a sprite draw adds a read and a write state
// per sprite row. A new request is taken while the previous result
// still waits in the output register.
module chip8_instruction_core import c8i_pkg::*; #(
  parameter logic [ADDR_W-1:0] ProgramStart = PROGRAM_START
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             func_i,
  input  wire logic [ADDR_W-1:0]      mem_address_i,
  input  wire logic [7:0]             mem_data_i,
  input  wire logic [ROW_W-1:0]       row_select_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [ADDR_W-1:0]           prog_count_o,
  output logic [15:0]                 instr_word_o,
  output logic [7:0]                  flag_reg_o,
  output logic [SCREEN_COLS-1:0]      row_bits_o
);

  c8i_cmd_t    cmd;
  c8i_status_t status;

  c8i_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  c8i_dpath #(
    .ProgramStart (ProgramStart)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (func_i),
    .mem_address_i (mem_address_i),
    .mem_data_i    (mem_data_i),
    .row_select_i  (row_select_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prog_count_o  (prog_count_o),
    .instr_word_o  (instr_word_o),
    .flag_reg_o    (flag_reg_o),
    .row_bits_o    (row_bits_o)
  );

  // Accepting a request drops ready: the core leaves the idle state to serve it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("core ready again right after accepting a request");

  // A new result is only produced while the core is busy with a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !in_ready_o)
    else $error("result produced while core idle");

  // Row bits are nonzero only for display reads; checked on step results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && (instr_word_o != 16'd0) |-> (row_bits_o == '0))
    else $error("step result carries display bits");

endmodule

`default_nettype wire
